// ===== src/kapc_pkg.sv =====
// ----------------------------------------------------------------------------
// kapc_pkg
// Shared types, codes and constant-divide helpers for the keyed alpha
// pixel compositor.
// ----------------------------------------------------------------------------
package kapc_pkg;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_TONE          = 3'd0,
		REG_ALPHA_GAIN    = 3'd1,
		REG_BLEND_TYPE    = 3'd2,
		REG_ALPHA_OPTIONS = 3'd3,
		REG_KEY_MODE      = 3'd4,
		REG_KEY_COLOR     = 3'd5,
		REG_KEY_INDEX     = 3'd6
	} reg_idx_t;

	typedef enum logic [1:0] {
		BLEND_COPY = 2'd0,
		BLEND_MIX  = 2'd1,
		BLEND_ADD  = 2'd2,
		BLEND_SUB  = 2'd3
	} blend_t;

	localparam logic [1:0] KEY_NONE  = 2'd0;
	localparam logic [1:0] KEY_RGB   = 2'd1;
	localparam logic [1:0] KEY_INDEX = 2'd2;

	// alpha option bits
	localparam int OPT_DOUBLE    = 0;
	localparam int OPT_INVERT    = 1;
	localparam int OPT_NONZERO   = 2;
	localparam int OPT_SRC_ALPHA = 3;

	localparam logic [9:0]  TONE_RESET      = 10'd1000;
	localparam logic [7:0]  ALPHA_GAIN_RESET = 8'd255;
	localparam logic [7:0]  ALPHA_OPAQUE    = 8'hFF;
	localparam logic [7:0]  BYTE_MAX        = 8'd255;

	// reciprocal multipliers, exact for any 18-bit dividend
	localparam logic [18:0] DIV1000_MUL = 19'd268436; // ceil(2^28 / 1000)
	localparam logic [18:0] DIV255_MUL  = 19'd263173; // ceil(2^26 / 255)

	// floor(p / 1000), p below 2^18
	function automatic logic [8:0] div1000(input logic [17:0] p);
		logic [36:0] prod;
		prod = 37'(p) * 37'(DIV1000_MUL);
		return prod[36:28];
	endfunction

	// floor(p / 255), p below 1024 * 255 so the quotient fits ten bits
	function automatic logic [9:0] div255(input logic [17:0] p);
		logic [36:0] prod;
		prod = 37'(p) * 37'(DIV255_MUL);
		return prod[35:26];
	endfunction

	// saturate a nonnegative value to one byte
	function automatic logic [7:0] clamp_byte(input logic [10:0] v);
		return (v > 11'(BYTE_MAX)) ? BYTE_MAX : v[7:0];
	endfunction

endpackage

// ===== src/keyed_alpha_pixel_compositor_top.sv =====
// ----------------------------------------------------------------------------
// keyed_alpha_pixel_compositor_top
// Per-pixel color key, tone scale, alpha normalize/scale and blend onto a
// background pixel, as a six-stage streaming pipeline.
// ----------------------------------------------------------------------------
//
// channel   dir  width  contents (lowest bit first)
// s_*       in   72+1   tdata: src_color, src_index, bg_color; tuser: is_indexed
// m_*       out  32+1   tdata: pixel_out; tuser: was_keyed
// cfg_*     in   3+24   register index, write data (no read-back)
//
// one pixel transaction is taken per clock unless the pipeline stalls;
// from input to output register it passes six register stages (tone
// product, reciprocal divides, blend products, numerator select, divide
// by 255, final combine/saturate)
// stall: each stage loads when it is empty or the stage after it moves, so
// bubbles close up and a stalled output holds without loss or repeats
// reset: arst_n clears all valid bits and loads the register reset values;
// there is no clearing pass, the block is ready right after reset
//
module keyed_alpha_pixel_compositor_top
	import kapc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // src_color[31:0], src_index[39:32], bg_color[71:40]
	input  logic        s_tuser,   // is_indexed
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // pixel_out[31:0]
	output logic        m_tuser,   // was_keyed
	// configuration write port
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data
);

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	logic [9:0]  tone_q;
	logic [7:0]  alpha_gain_q;
	blend_t      blend_type_q;
	logic [3:0]  alpha_options_q;
	logic [1:0]  key_mode_q;
	logic [23:0] key_color_q;
	logic [7:0]  key_index_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tone_q          <= TONE_RESET;
			alpha_gain_q    <= ALPHA_GAIN_RESET;
			blend_type_q    <= BLEND_MIX;
			alpha_options_q <= '0;
			key_mode_q      <= KEY_NONE;
			key_color_q     <= '0;
			key_index_q     <= '0;
		end else if (cfg_wr_en) begin
			case (reg_idx_t'(cfg_index))
				REG_TONE:          tone_q          <= cfg_data[9:0];
				REG_ALPHA_GAIN:    alpha_gain_q    <= cfg_data[7:0];
				REG_BLEND_TYPE:    blend_type_q    <= blend_t'(cfg_data[1:0]);
				REG_ALPHA_OPTIONS: alpha_options_q <= cfg_data[3:0];
				REG_KEY_MODE:      key_mode_q      <= cfg_data[1:0];
				REG_KEY_COLOR:     key_color_q     <= cfg_data[23:0];
				REG_KEY_INDEX:     key_index_q     <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// stage enables: a stage loads when empty or when its successor loads
	// ------------------------------------------------------------------
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic adv1, adv2, adv3, adv4, adv5, adv6;

	assign adv6 = !v_s6 || m_tready;
	assign adv5 = !v_s5 || adv6;
	assign adv4 = !v_s4 || adv5;
	assign adv3 = !v_s3 || adv4;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;
	assign s_tready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= s_tvalid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv4) v_s4 <= v_s3;
			if (adv5) v_s5 <= v_s4;
			if (adv6) v_s6 <= v_s5;
		end
	end

	// ------------------------------------------------------------------
	// input unpack, alpha normalize, key match
	// ------------------------------------------------------------------
	logic [31:0] in_src;
	logic [7:0]  in_idx;
	logic [31:0] in_bg;
	logic [7:0]  a_norm;
	logic        rgb_match;
	logic        in_keyed;
	logic        in_skip;
	logic [15:0] a_x255;
	logic [8:0]  a_pre;

	assign in_src = s_tdata[31:0];
	assign in_idx = s_tdata[39:32];
	assign in_bg  = s_tdata[71:40];

	always_comb begin
		// no source alpha means opaque; optional inversion otherwise
		if (alpha_options_q[OPT_SRC_ALPHA])
			a_norm = alpha_options_q[OPT_INVERT] ? ~in_src[31:24] : in_src[31:24];
		else
			a_norm = ALPHA_OPAQUE;

		rgb_match = (in_src[23:0] == key_color_q);
		if (s_tuser) begin
			// indexed source: mode picks the key kind, other codes do not key
			if (key_mode_q == KEY_RGB)
				in_keyed = rgb_match;
			else if (key_mode_q == KEY_INDEX)
				in_keyed = (in_idx == key_index_q);
			else
				in_keyed = 1'b0;
		end else begin
			// direct color: any key mode keys by rgb
			in_keyed = (key_mode_q != KEY_NONE) && rgb_match;
		end

		in_skip = alpha_options_q[OPT_NONZERO] && (a_norm == '0);

		// doubled alpha is a*255/128
		a_x255 = {a_norm, 8'd0} - 16'(a_norm);
		a_pre  = alpha_options_q[OPT_DOUBLE] ? a_x255[15:7] : {1'b0, a_norm};
	end

	// ------------------------------------------------------------------
	// stage 1: tone products and alpha gain product
	// ------------------------------------------------------------------
	logic [2:0][17:0] tp_s1;   // lanes: 0 blue, 1 green, 2 red
	logic [16:0]      ap_s1;
	logic [31:0]      bg_s1;
	logic             keyed_s1, skip_s1;

	always_ff @(posedge clk) begin
		if (adv1) begin
			for (int i = 0; i < 3; i++)
				tp_s1[i] <= 18'(in_src[8*i +: 8]) * 18'(tone_q);
			ap_s1    <= 17'(a_pre) * 17'(alpha_gain_q);
			bg_s1    <= in_bg;
			keyed_s1 <= in_keyed;
			skip_s1  <= in_skip;
		end
	end

	// ------------------------------------------------------------------
	// stage 2: divide by 1000 and by 255 through reciprocal products
	// ------------------------------------------------------------------
	logic [2:0][8:0] sc_s2;    // toned component, up to 260
	logic [8:0]      a_s2;     // scaled alpha, up to 508
	logic [31:0]     bg_s2;
	logic            keyed_s2, skip_s2;
	logic [9:0]      a_div;

	assign a_div = div255({1'b0, ap_s1});

	always_ff @(posedge clk) begin
		if (adv2) begin
			for (int i = 0; i < 3; i++)
				sc_s2[i] <= div1000(tp_s1[i]);
			a_s2     <= a_div[8:0];
			bg_s2    <= bg_s1;
			keyed_s2 <= keyed_s1;
			skip_s2  <= skip_s1;
		end
	end

	// ------------------------------------------------------------------
	// stage 3: blend products s*a and d*(255-a), the latter signed
	// ------------------------------------------------------------------
	logic [2:0][17:0]        sa_s3;
	logic signed [2:0][18:0] dn_s3;
	logic [2:0][8:0]         sc_s3;
	logic [31:0]             bg_s3;
	logic                    keyed_s3, skip_s3;
	logic signed [10:0]      inv_a;
	logic signed [2:0][19:0] dn_full;

	always_comb begin
		inv_a = 11'sd255 - $signed({2'b00, a_s2});
		for (int i = 0; i < 3; i++)
			dn_full[i] = 20'($signed({1'b0, bg_s2[8*i +: 8]})) * 20'(inv_a);
	end

	always_ff @(posedge clk) begin
		if (adv3) begin
			for (int i = 0; i < 3; i++) begin
				sa_s3[i] <= 18'(sc_s2[i]) * 18'(a_s2);
				dn_s3[i] <= dn_full[i][18:0];
			end
			sc_s3    <= sc_s2;
			bg_s3    <= bg_s2;
			keyed_s3 <= keyed_s2;
			skip_s3  <= skip_s2;
		end
	end

	// ------------------------------------------------------------------
	// stage 4: dividend select; a negative mix sum truncates to zero
	// ------------------------------------------------------------------
	logic [2:0][17:0]        num_s4;
	logic [2:0][8:0]         sc_s4;
	logic [31:0]             bg_s4;
	logic                    keyed_s4, skip_s4;
	logic signed [2:0][19:0] mix_sum;
	logic [2:0][17:0]        num_nxt;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			// lane selects of a packed array are unsigned, so re-sign before extending
			mix_sum[i] = $signed({2'b00, sa_s3[i]}) + 20'($signed(dn_s3[i]));
			if (blend_type_q == BLEND_MIX)
				num_nxt[i] = mix_sum[i][19] ? 18'd0 : mix_sum[i][17:0];
			else
				num_nxt[i] = sa_s3[i];
		end
	end

	always_ff @(posedge clk) begin
		if (adv4) begin
			num_s4   <= num_nxt;
			sc_s4    <= sc_s3;
			bg_s4    <= bg_s3;
			keyed_s4 <= keyed_s3;
			skip_s4  <= skip_s3;
		end
	end

	// ------------------------------------------------------------------
	// stage 5: divide by 255
	// ------------------------------------------------------------------
	logic [2:0][9:0] q_s5;
	logic [2:0][8:0] sc_s5;
	logic [31:0]     bg_s5;
	logic            keyed_s5, skip_s5;

	always_ff @(posedge clk) begin
		if (adv5) begin
			for (int i = 0; i < 3; i++)
				q_s5[i] <= div255(num_s4[i]);
			sc_s5    <= sc_s4;
			bg_s5    <= bg_s4;
			keyed_s5 <= keyed_s4;
			skip_s5  <= skip_s4;
		end
	end

	// ------------------------------------------------------------------
	// stage 6: final combine and saturate into the output register
	// ------------------------------------------------------------------
	logic [31:0]     pix_s6;
	logic            keyed_s6;
	logic [2:0][7:0] lane_res;
	logic [7:0]      d_b;
	logic [10:0]     add_sum;

	always_comb begin
		d_b     = '0;
		add_sum = '0;
		for (int i = 0; i < 3; i++) begin
			d_b     = bg_s5[8*i +: 8];
			add_sum = 11'(q_s5[i]) + 11'(d_b);
			if (skip_s5) begin
				lane_res[i] = clamp_byte(11'(sc_s5[i]));
			end else begin
				case (blend_type_q)
					BLEND_COPY: lane_res[i] = clamp_byte(11'(sc_s5[i]));
					BLEND_MIX:  lane_res[i] = clamp_byte(11'(q_s5[i]));
					BLEND_ADD:  lane_res[i] = clamp_byte(add_sum);
					BLEND_SUB:  lane_res[i] = (10'(d_b) >= q_s5[i]) ?
						8'(10'(d_b) - q_s5[i]) : 8'd0;
					default:    lane_res[i] = clamp_byte(11'(sc_s5[i]));
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv6) begin
			// keyed pixel passes the background untouched, alpha included
			pix_s6   <= keyed_s5 ? bg_s5 : {8'd0, lane_res[2], lane_res[1], lane_res[0]};
			keyed_s6 <= keyed_s5;
		end
	end

	assign m_tvalid = v_s6;
	assign m_tdata  = pix_s6;
	assign m_tuser  = keyed_s6;

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	// input side only backs up when the first stage holds an item
	a_ready_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> v_s1)
		else $error("input stalled with empty first stage");

	// a blended result always carries zero alpha
	a_blend_alpha_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata[31:24] == 8'd0))
		else $error("blended pixel with nonzero alpha");

	// an item in stage five moves into an empty output register
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s5 && !v_s6) |=> v_s6)
		else $error("item lost before output register");

	// quotient of the final divide never exceeds 771
	a_quot_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 |-> (q_s5[0] <= 10'd771 && q_s5[1] <= 10'd771 && q_s5[2] <= 10'd771))
		else $error("divide by 255 out of range");

endmodule

// ===== tb/sv/keyed_alpha_pixel_compositor_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// keyed_alpha_pixel_compositor_top_tb
// Streams source/background pixel pairs through the compositor under a series
// of register settings and checks every output transaction, in order, against
// a behavioral composite (color key, tone, alpha scaling, blend) or a typed row.
// ----------------------------------------------------------------------------
module keyed_alpha_pixel_compositor_top_tb;
	import kapc_pkg::*;

	// key mode three has no name in the package: rgb key for direct pixels,
	// no key at all for indexed ones
	localparam logic [1:0] KEY_MODE3 = 2'd3;

	// alpha option masks built from the package bit positions
	localparam logic [3:0] AO_DBL = 4'(1 << OPT_DOUBLE);
	localparam logic [3:0] AO_INV = 4'(1 << OPT_INVERT);
	localparam logic [3:0] AO_NZ  = 4'(1 << OPT_NONZERO);
	localparam logic [3:0] AO_SRC = 4'(1 << OPT_SRC_ALPHA);

	localparam int PIPE_LAT    = 6;     // pipeline depth, input to output register
	localparam int HOLD_CYCLES = 300;   // long receiver hold-off, fills the pipeline
	localparam int QUIET_LIMIT = 2000;  // cycles with no transaction before giving up
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 40;
	localparam int NDIR        = 26;

	typedef struct packed {
		logic [9:0]  tone;
		logic [7:0]  gain;
		blend_t      blend;
		logic [3:0]  opts;
		logic [1:0]  kmode;
		logic [23:0] kcolor;
		logic [7:0]  kidx;
	} cfg_t;

	typedef struct packed {
		logic [31:0] src;
		logic [7:0]  idx;
		logic        indexed;
		logic [31:0] bg;
	} px_in_t;

	typedef struct packed {
		logic [31:0] pixel;
		logic        keyed;
	} px_out_t;

	// one directed row: settings, pixel, and a hand-written result where obvious
	typedef struct packed {
		cfg_t    cfg;
		px_in_t  px;
		logic    typed;
		px_out_t res;
	} dir_row_t;

	// register settings used by the directed rows
	localparam cfg_t C_RST  = '{10'd1000, 8'd255, BLEND_MIX, 4'h0, KEY_NONE, 24'h0, 8'h00};
	localparam cfg_t C_KRGB = '{10'd1000, 8'd255, BLEND_MIX, 4'h0, KEY_RGB, 24'h123456, 8'h00};
	localparam cfg_t C_KIDX = '{10'd1000, 8'd255, BLEND_MIX, 4'h0, KEY_INDEX, 24'h00FF00, 8'h5A};
	localparam cfg_t C_KM3  = '{10'd1000, 8'd255, BLEND_MIX, 4'h0, KEY_MODE3, 24'h00FF00, 8'h5A};
	localparam cfg_t C_COPY = '{10'd1000, 8'd255, BLEND_COPY, 4'h0, KEY_NONE, 24'h0, 8'h00};
	localparam cfg_t C_HOT  = '{10'd1023, 8'd255, BLEND_COPY, 4'h0, KEY_NONE, 24'h0, 8'h00};
	localparam cfg_t C_DARK = '{10'd0, 8'd255, BLEND_COPY, 4'h0, KEY_NONE, 24'h0, 8'h00};
	localparam cfg_t C_SRCA = '{10'd1000, 8'd255, BLEND_MIX, AO_SRC, KEY_NONE, 24'h0, 8'h00};
	localparam cfg_t C_INV  = '{10'd1000, 8'd255, BLEND_MIX, AO_SRC | AO_INV, KEY_NONE,
		24'h0, 8'h00};
	localparam cfg_t C_NZ   = '{10'd1000, 8'd255, BLEND_MIX, AO_SRC | AO_NZ, KEY_NONE,
		24'h0, 8'h00};
	localparam cfg_t C_DBL  = '{10'd1000, 8'd255, BLEND_MIX, AO_SRC | AO_DBL, KEY_NONE,
		24'h0, 8'h00};
	localparam cfg_t C_ADD  = '{10'd1000, 8'd255, BLEND_ADD, 4'h0, KEY_NONE, 24'h0, 8'h00};
	localparam cfg_t C_SUB  = '{10'd1000, 8'd255, BLEND_SUB, 4'h0, KEY_NONE, 24'h0, 8'h00};
	localparam cfg_t C_MUTE = '{10'd1000, 8'd0, BLEND_MIX, 4'h0, KEY_NONE, 24'h0, 8'h00};
	localparam cfg_t C_ALL  = '{10'd1000, 8'd200, BLEND_MIX, 4'hF, KEY_NONE, 24'h0, 8'h00};
	localparam cfg_t C_KMAX = '{10'd1000, 8'd255, BLEND_MIX, 4'h0, KEY_RGB, 24'hFFFFFF, 8'hFF};
	localparam cfg_t C_IMAX = '{10'd1000, 8'd255, BLEND_MIX, 4'h0, KEY_INDEX, 24'hFFFFFF,
		8'hFF};
	// extremes for the first two random phases
	localparam cfg_t C_MIN  = '{10'd0, 8'd0, BLEND_COPY, 4'h0, KEY_NONE, 24'h0, 8'h00};
	localparam cfg_t C_MAX  = '{10'd1023, 8'd255, BLEND_SUB, 4'hF, KEY_MODE3, 24'hFFFFFF,
		8'hFF};

	localparam px_out_t NO_RES = '0;

	// directed rows: src, idx, indexed, bg; typed result where it is plain
	dir_row_t dir_tab [NDIR] = '{
		// reset settings, opaque white onto black and black onto white
		'{C_RST,  '{32'hFFFFFFFF, 8'h00, 1'b0, 32'h00000000}, 1'b1, '{32'h00FFFFFF, 1'b0}},
		'{C_RST,  '{32'h00000000, 8'h00, 1'b0, 32'hFFFFFFFF}, 1'b1, '{32'h00000000, 1'b0}},
		'{C_RST,  '{32'h12345678, 8'hC3, 1'b0, 32'h9ABCDEF0}, 1'b0, NO_RES},
		// rgb key, direct and indexed, and a near miss
		'{C_KRGB, '{32'h00123456, 8'h00, 1'b0, 32'hDEADBEEF}, 1'b1, '{32'hDEADBEEF, 1'b1}},
		'{C_KRGB, '{32'hAB123456, 8'h77, 1'b1, 32'h01020304}, 1'b1, '{32'h01020304, 1'b1}},
		'{C_KRGB, '{32'h00123457, 8'h00, 1'b0, 32'h55AA55AA}, 1'b0, NO_RES},
		// index key; direct pixels still key by rgb in this mode
		'{C_KIDX, '{32'h80000000, 8'h5A, 1'b1, 32'hFFFFFFFF}, 1'b1, '{32'hFFFFFFFF, 1'b1}},
		'{C_KIDX, '{32'h0000FF00, 8'h00, 1'b0, 32'h12345678}, 1'b1, '{32'h12345678, 1'b1}},
		'{C_KIDX, '{32'h0000FF00, 8'h5B, 1'b1, 32'h12345678}, 1'b0, NO_RES},
		// key mode three: no key for indexed, rgb key for direct
		'{C_KM3,  '{32'h0000FF00, 8'h5A, 1'b1, 32'h12345678}, 1'b0, NO_RES},
		'{C_KM3,  '{32'h0000FF00, 8'h5A, 1'b0, 32'h87654321}, 1'b1, '{32'h87654321, 1'b1}},
		// copy, with tone at unity, above 1000 and zero
		'{C_COPY, '{32'h80FF0080, 8'h00, 1'b0, 32'h11223344}, 1'b1, '{32'h00FF0080, 1'b0}},
		'{C_HOT,  '{32'h00FFFFFF, 8'h00, 1'b0, 32'h00000000}, 1'b1, '{32'h00FFFFFF, 1'b0}},
		'{C_HOT,  '{32'h00C86401, 8'h00, 1'b0, 32'h00000000}, 1'b0, NO_RES},
		'{C_DARK, '{32'hFFFFFFFF, 8'h00, 1'b0, 32'hAABBCCDD}, 1'b1, '{32'h00000000, 1'b0}},
		// source alpha: zero alpha passes background rgb, inverted opaque too
		'{C_SRCA, '{32'h00FFFFFF, 8'h00, 1'b0, 32'hAA123456}, 1'b1, '{32'h00123456, 1'b0}},
		'{C_INV,  '{32'hFFFFFFFF, 8'h00, 1'b0, 32'hAA123456}, 1'b1, '{32'h00123456, 1'b0}},
		// blend skipped on zero alpha: toned source comes out
		'{C_NZ,   '{32'h00804020, 8'h00, 1'b0, 32'hFFFFFFFF}, 1'b1, '{32'h00804020, 1'b0}},
		// doubled alpha goes past 255, mix turns signed
		'{C_DBL,  '{32'hFF102030, 8'h00, 1'b0, 32'h00F0E0D0}, 1'b0, NO_RES},
		'{C_DBL,  '{32'h81FFFFFF, 8'h00, 1'b0, 32'h00000000}, 1'b0, NO_RES},
		// additive saturates high, subtractive floors at zero; then zero gain and all options
		'{C_ADD,  '{32'hFFFFFFFF, 8'h00, 1'b0, 32'h00808080}, 1'b1, '{32'h00FFFFFF, 1'b0}},
		'{C_SUB,  '{32'hFFFFFFFF, 8'h00, 1'b0, 32'hFF808080}, 1'b1, '{32'h00000000, 1'b0}},
		'{C_MUTE, '{32'hFFFFFFFF, 8'h00, 1'b0, 32'h11223344}, 1'b1, '{32'h00223344, 1'b0}},
		'{C_ALL,  '{32'h00FF8040, 8'h03, 1'b1, 32'h7F7F7F7F}, 1'b0, NO_RES},
		// keys at their largest values
		'{C_KMAX, '{32'h00FFFFFF, 8'h00, 1'b0, 32'hFFFFFFFF}, 1'b1, '{32'hFFFFFFFF, 1'b1}},
		'{C_IMAX, '{32'h00000000, 8'hFF, 1'b1, 32'h01234567}, 1'b1, '{32'h01234567, 1'b1}}
	};

	// dut ports; every input is known from time zero
	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [71:0] s_tdata   = '0;   // src_color[31:0], src_index[39:32], bg_color[71:40]
	logic        s_tuser   = 1'b0; // is_indexed
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [31:0] m_tdata;          // pixel_out[31:0]
	logic        m_tuser;          // was_keyed
	logic        cfg_wr_en = 1'b0;
	reg_idx_t    cfg_index = REG_TONE;
	logic [23:0] cfg_data  = '0;

	cfg_t        cur_cfg = C_RST;  // settings the block holds right now
	px_out_t     pixel_q [$];      // composited pixels still to come out
	int          fail_count = 0;
	int unsigned quiet_cycles = 0;
	bit          hold_req = 1'b0;
	bit          hold_active = 1'b0;

	keyed_alpha_pixel_compositor_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------------
	// composite predictor
	// ------------------------------------------------------------------------
	function automatic logic [7:0] sat8(longint v);
		if (v > 255)
			return 8'd255;
		if (v < 0)
			return 8'd0;
		return v[7:0];
	endfunction

	// one color channel; signed math, division truncates toward zero
	function automatic logic [7:0] blend_chan(blend_t bt, longint s, longint d, longint a);
		case (bt)
			BLEND_MIX: return sat8((s * a + d * (255 - a)) / 255);
			BLEND_ADD: return sat8(s * a / 255 + d);
			BLEND_SUB: return sat8(d - s * a / 255);
			default:   return sat8(s);
		endcase
	endfunction

	function automatic px_out_t composite(cfg_t c, px_in_t p);
		logic [31:0] src;
		logic        hit;
		longint      a0;
		longint      a;
		longint      toned;
		blend_t      mode;
		px_out_t     o;
		src = p.src;
		// alpha normalize: optional invert when the source has alpha, else opaque
		if (c.opts[OPT_SRC_ALPHA]) begin
			if (c.opts[OPT_INVERT])
				src[31:24] = ~src[31:24];
		end else begin
			src[31:24] = ALPHA_OPAQUE;
		end
		if (p.indexed) begin
			case (c.kmode)
				KEY_RGB:   hit = (src[23:0] == c.kcolor);
				KEY_INDEX: hit = (p.idx == c.kidx);
				default:   hit = 1'b0;
			endcase
		end else begin
			hit = (c.kmode != KEY_NONE) && (src[23:0] == c.kcolor);
		end
		if (hit)
			return '{p.bg, 1'b1};
		a0 = longint'(src[31:24]);
		a = a0;
		if (c.opts[OPT_DOUBLE])
			a = a * 255 / 128;
		a = a * longint'(c.gain) / 255;
		// zero alpha with the nonzero option skips the blend, copy just saturates
		mode = (c.opts[OPT_NONZERO] && a0 == 0) ? BLEND_COPY : c.blend;
		o.pixel = '0;
		for (int k = 0; k < 3; k++) begin
			toned = longint'(src[8*k +: 8]) * longint'(c.tone) / 1000;
			o.pixel[8*k +: 8] = blend_chan(mode, toned, longint'(p.bg[8*k +: 8]), a);
		end
		o.keyed = 1'b0;
		return o;
	endfunction

	// ------------------------------------------------------------------------
	// random settings and pixels
	// ------------------------------------------------------------------------
	function automatic cfg_t rand_cfg();
		cfg_t c;
		case ($urandom_range(0, 3))
			0:       c.tone = 10'd0;
			1:       c.tone = 10'd1000;
			2:       c.tone = 10'd1023;
			default: c.tone = 10'($urandom_range(0, 1023));
		endcase
		case ($urandom_range(0, 2))
			0:       c.gain = 8'd0;
			1:       c.gain = 8'd255;
			default: c.gain = 8'($urandom);
		endcase
		c.blend  = blend_t'($urandom_range(0, 3));
		c.opts   = 4'($urandom);
		c.kmode  = 2'($urandom);
		c.kcolor = 24'($urandom);
		c.kidx   = 8'($urandom);
		return c;
	endfunction

	// random pixel, steered onto the key and the alpha extremes now and then
	function automatic px_in_t rand_pixel(cfg_t c);
		px_in_t p;
		p.src     = $urandom;
		p.idx     = 8'($urandom);
		p.indexed = 1'($urandom);
		p.bg      = $urandom;
		if ($urandom_range(0, 3) == 0)
			p.src[23:0] = c.kcolor;
		if ($urandom_range(0, 3) == 0)
			p.idx = c.kidx;
		case ($urandom_range(0, 7))
			0:       p.src[31:24] = 8'h00;
			1:       p.src[31:24] = 8'hFF;
			default: ;
		endcase
		return p;
	endfunction

	// ------------------------------------------------------------------------
	// sender side: drive on the falling edge, hold until the transaction
	// ------------------------------------------------------------------------
	task automatic offer(px_in_t p, logic typed, px_out_t res);
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= {p.bg, p.idx, p.src};
		s_tuser  <= p.indexed;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		// accepted at this edge, queue what it must turn into
		pixel_q.push_back(typed ? res : composite(cur_cfg, p));
	endtask

	// lower tvalid to pause the sender; an argument of zero keeps the burst going
	task automatic pause(int n);
		if (n > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (n - 1)
				@(negedge clk);
		end
	endtask

	// sender quiet until every composited pixel is out, plus the pipe depth
	task automatic drain();
		pause(1);
		while (pixel_q.size() != 0)
			@(posedge clk);
		repeat (PIPE_LAT + 2)
			@(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t r, logic [23:0] d);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= r;
		cfg_data  <= d;
	endtask

	// new settings go in only with the pipeline empty
	task automatic load_cfg(cfg_t c);
		drain();
		write_reg(REG_TONE,          24'(c.tone));
		write_reg(REG_ALPHA_GAIN,    24'(c.gain));
		write_reg(REG_BLEND_TYPE,    24'(c.blend));
		write_reg(REG_ALPHA_OPTIONS, 24'(c.opts));
		write_reg(REG_KEY_MODE,      24'(c.kmode));
		write_reg(REG_KEY_COLOR,     c.kcolor);
		write_reg(REG_KEY_INDEX,     24'(c.kidx));
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		cur_cfg = c;
	endtask

	// ------------------------------------------------------------------------
	// receiver side: stall pattern in runs of random mode, or one long
	// hold-off on request so the input side backs up
	// ------------------------------------------------------------------------
	initial begin : sink_pattern
		int run;
		int mode;
		forever begin
			if (hold_req) begin
				hold_active = 1'b1;
				hold_req = 1'b0;
				@(negedge clk);
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES)
					@(negedge clk);
				hold_active = 1'b0;
			end else begin
				run  = $urandom_range(1, 40);
				mode = $urandom_range(0, 3);
				repeat (run) begin
					@(negedge clk);
					case (mode)
						0:       m_tready <= 1'b1;                          // no stalls
						1:       m_tready <= 1'($urandom);                  // half and half
						2:       m_tready <= ($urandom_range(0, 4) != 0);   // mostly ready
						default: m_tready <= ($urandom_range(0, 4) == 0);   // mostly stalled
					endcase
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// output check: each output transaction against the oldest expectation
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : result_check
		px_out_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pixel_q.size() == 0) begin
				fail_count++;
				$display("%0t: result with nothing expected: pixel_out %h was_keyed %b",
					$time, m_tdata, m_tuser);
			end else begin
				want = pixel_q.pop_front();
				if (m_tdata !== want.pixel) begin
					fail_count++;
					$display("%0t: pixel_out expected %h actual %h",
						$time, want.pixel, m_tdata);
				end
				if (m_tuser !== want.keyed) begin
					fail_count++;
					$display("%0t: was_keyed expected %b actual %b",
						$time, want.keyed, m_tuser);
				end
			end
		end
	end

	// watchdog: too long with no transaction on any port means a hang
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: timeout, %0d results outstanding", $time, pixel_q.size());
			$display("Mismatches found");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------------
	initial begin : stimulus
		cfg_t c;
		int   n;
		int   burst;
		repeat (11)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed table; settings change only between rows that need it
		for (int i = 0; i < NDIR; i++) begin
			if (dir_tab[i].cfg != cur_cfg)
				load_cfg(dir_tab[i].cfg);
			offer(dir_tab[i].px, dir_tab[i].typed, dir_tab[i].res);
		end

		// random phases, each under its own settings, extremes first
		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph == 0)
				c = C_MIN;
			else if (ph == 1)
				c = C_MAX;
			else
				c = rand_cfg();
			load_cfg(c);
			if (ph == 3) begin
				// back-to-back pixels into a held-off output: pipeline fills up
				hold_req = 1'b1;
				while (!hold_active)
					@(posedge clk);
				repeat (40)
					offer(rand_pixel(cur_cfg), 1'b0, NO_RES);
			end
			n = 0;
			while (n < PHASE_ITEMS) begin
				burst = $urandom_range(1, 16);
				repeat (burst) begin
					offer(rand_pixel(cur_cfg), 1'b0, NO_RES);
					n++;
				end
				// a quarter of the bursts run straight into the next one
				pause(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
			end
		end

		drain();
		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
